/* rtl/core/cpsp_pkg.sv */
// Shared types and constants for the circular pair-sum power block.
`timescale 1ns / 1ps

package cpsp_pkg;

    localparam int VALUE_W = 7;
    localparam int POWER_W = 31;
    localparam int MODULUS = 100;

    // floor(a / 100) == (a * RECIP_K) >> RECIP_SHIFT for a below 2^23
    localparam int RECIP_W = 24;
    localparam logic [RECIP_W-1:0] RECIP_K = 24'd10737419;
    localparam int RECIP_SHIFT = 30;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;

    typedef struct packed {
        logic [VALUE_W-1:0] element_value;
        logic               element_last;
        logic [POWER_W-1:0] step_power;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic               result_last;
    } t_out_word;

    // classified word: value already reduced, power already masked
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [POWER_W-1:0] power;
    } t_q_word;

endpackage

/* rtl/core/circular_pair_sum_power_mod100_core.sv */
// Top level of the circular pair-sum power block (mod 100).
//
// Input channel: one element word per handshake (i_in_valid / o_in_stall).
// Each word is stored; the word with element_last set also carries the
// power k and starts the computation on the stored vector (at most N_MAX
// elements, extra ones dropped). Output channel: n result words, the last
// one marked by result_last (o_out_valid / i_out_stall).
// Loading: one word per cycle through a short queue while the engine loads.
// Computing: for each of the bit positions up to the top set bit of k,
// one squaring and, for set bits, one vector product, both run on the
// shared multiply-accumulate unit. Output: each result word is read from
// the vector memory and loaded into the output register; a stalled
// receiver holds the output register and the engine waits, while the
// input queue keeps taking words until it is full.
// Reset (synchronous, active low) empties the queue and output register
// and clears the element count; no memory is cleared.
`timescale 1ns / 1ps

module circular_pair_sum_power_mod100_core
    import cpsp_pkg::*;
#(
    parameter int N_MAX      = 32,
    parameter int POWER_BITS = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic    f_valid, f_stall;
    t_q_word f_word;
    logic    q_valid, q_stall;
    t_q_word q_word;

    cpsp_front #(.POWER_BITS(POWER_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_stall(o_in_stall), .i_word(i_in_word),
        .o_valid(f_valid), .i_stall(f_stall), .o_word(f_word)
    );

    cpsp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_stall(f_stall), .i_word(f_word),
        .o_valid(q_valid), .i_stall(q_stall), .o_word(q_word)
    );

    cpsp_back #(.N_MAX(N_MAX)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_stall(q_stall), .i_word(q_word),
        .o_valid(o_out_valid), .i_stall(i_out_stall), .o_word(o_out_word)
    );

endmodule

/* rtl/core/cpsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cpsp_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/cpsp_front.sv */
// Input stage: reduces the element mod 100 and masks the power.
`timescale 1ns / 1ps

module cpsp_front
    import cpsp_pkg::*;
#(
    parameter int POWER_BITS = 31
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_word i_word,
    output logic     o_valid,
    input  logic     i_stall,
    output t_q_word  o_word
);

    logic    r_valid;
    t_q_word r_word;
    t_q_word w_cls;
    logic    w_accept;

    always_comb begin
        w_cls.value = (i_word.element_value >= VALUE_W'(MODULUS))
                    ? i_word.element_value - VALUE_W'(MODULUS)
                    : i_word.element_value;
        w_cls.last = i_word.element_last;
        for (int i = 0; i < POWER_W; i++) begin
            w_cls.power[i] = i_word.step_power[i] && (i < POWER_BITS);
        end
    end

    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= w_cls;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

/* rtl/core/cpsp_queue.sv */
// Short word queue between the input stage and the compute engine.
`timescale 1ns / 1ps

module cpsp_queue
    import cpsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_q_word i_word,
    output logic    o_valid,
    input  logic    i_stall,
    output t_q_word o_word
);

    t_q_word         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_stall = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;
    assign o_word  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

endmodule

/* rtl/core/cpsp_back.sv */
// Compute engine: stores the vector, runs square-and-multiply, emits results.
`timescale 1ns / 1ps

module cpsp_back
    import cpsp_pkg::*;
#(
    parameter int N_MAX = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_q_word   i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    localparam int AW    = (N_MAX > 1) ? $clog2(N_MAX) : 1;
    localparam int CW    = $clog2(N_MAX + 1);
    localparam int ACC_W = $clog2(N_MAX * 9801 + 1);
    localparam int QP_W  = ACC_W + RECIP_W;

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_INIT  = 11'b00000000010,
        S_BIT   = 11'b00000000100,
        S_MAC   = 11'b00000001000,
        S_DRAIN = 11'b00000010000,
        S_RED   = 11'b00000100000,
        S_WRS   = 11'b00001000000,
        S_COPY  = 11'b00010000000,
        S_CEND  = 11'b00100000000,
        S_ORD   = 11'b01000000000,
        S_OLD   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_j, n_j;
    logic [CW-1:0]      r_t, n_t;
    logic [CW-1:0]      r_d, n_d;
    logic [POWER_W-1:0] r_pow, n_pow;
    logic               r_sq, n_sq;

    logic               r_v1, r_v2, r_cv;
    logic [CW-1:0]      r_cj;
    logic [13:0]        r_p;
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   r_q;
    logic               r_ov;
    t_out_word          r_out;

    logic               w_pop;
    logic               w_room;
    logic               w_take;
    logic [CW:0]        w_yidx;
    logic [QP_W-1:0]    w_qprod;
    logic [VALUE_W-1:0] w_rem;

    logic               v_we, ra_we, s_we;
    logic [AW-1:0]      v_wa, ra_wa, v_ra, ra_ra, rb_ra;
    logic [VALUE_W-1:0] v_wd, ra_wd, v_rd, ra_rd, rb_rd, s_rd;
    logic [VALUE_W-1:0] w_x, w_y;

    assign o_stall = (r_state != S_LOAD);
    assign w_pop   = i_valid && !o_stall;
    assign w_room  = (r_count < CW'(N_MAX));
    assign w_take  = !r_ov || !i_stall;

    // y index of the cyclic convolution: (d - t) mod n
    assign w_yidx = (r_d >= r_t) ? {1'b0, r_d} - {1'b0, r_t}
                                 : {1'b0, r_d} + {1'b0, r_n} - {1'b0, r_t};

    assign w_qprod = QP_W'(r_acc) * QP_W'(RECIP_K);
    assign w_rem   = VALUE_W'(r_acc - ACC_W'(r_q * ACC_W'(MODULUS)));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_n     = r_n;
        n_j     = r_j;
        n_t     = r_t;
        n_d     = r_d;
        n_pow   = r_pow;
        n_sq    = r_sq;
        unique case (r_state)
            S_LOAD: begin
                if (w_pop) begin
                    if (w_room) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_word.last) begin
                        n_n     = w_room ? r_count + 1'b1 : r_count;
                        n_pow   = i_word.power;
                        n_j     = '0;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                n_j = r_j + 1'b1;
                if (r_j == r_n - 1'b1) begin
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (r_pow == '0) begin
                    n_j     = '0;
                    n_state = S_ORD;
                end else begin
                    n_sq    = !r_pow[0];
                    n_d     = '0;
                    n_t     = '0;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                n_t = r_t + 1'b1;
                if (r_t == r_n - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_RED;
                end
            end
            S_RED: begin
                n_state = S_WRS;
            end
            S_WRS: begin
                n_d = r_d + 1'b1;
                n_t = '0;
                if (r_d == r_n - 1'b1) begin
                    n_j     = '0;
                    n_state = S_COPY;
                end else begin
                    n_state = S_MAC;
                end
            end
            S_COPY: begin
                n_j = r_j + 1'b1;
                if (r_j == r_n - 1'b1) begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                if (!r_sq) begin
                    // vector product done, now square the row
                    n_sq    = 1'b1;
                    n_d     = '0;
                    n_t     = '0;
                    n_state = S_MAC;
                end else begin
                    n_pow   = r_pow >> 1;
                    n_state = S_BIT;
                end
            end
            S_ORD: begin
                n_state = S_OLD;
            end
            S_OLD: begin
                if (w_take) begin
                    n_j = r_j + 1'b1;
                    if (r_j == r_n - 1'b1) begin
                        n_count = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_cv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_v1    <= (r_state == S_MAC);
            r_v2    <= r_v1;
            r_cv    <= (r_state == S_COPY);
            if (r_state == S_OLD && w_take) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_j   <= n_j;
        r_t   <= n_t;
        r_d   <= n_d;
        r_pow <= n_pow;
        r_sq  <= n_sq;
        r_cj  <= r_j;
        if (r_v1) begin
            r_p <= 14'(w_x) * 14'(w_y);
        end
        if (r_state == S_BIT || r_state == S_WRS || r_state == S_CEND) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_p);
        end
        if (r_state == S_RED) begin
            r_q <= ACC_W'(w_qprod >> RECIP_SHIFT);
        end
        if (r_state == S_OLD && w_take) begin
            r_out.result_value <= v_rd;
            r_out.result_last  <= (r_j == r_n - 1'b1);
        end
    end

    assign o_valid = r_ov;
    assign o_word  = r_out;

    // memory ports
    assign w_x = r_sq ? ra_rd : v_rd;
    assign w_y = r_sq ? rb_rd : ra_rd;

    assign v_we  = (r_state == S_LOAD && w_pop && w_room) || (r_cv && !r_sq);
    assign v_wa  = r_cv ? r_cj[AW-1:0] : r_count[AW-1:0];
    assign v_wd  = r_cv ? s_rd : i_word.value;
    assign v_ra  = (r_state == S_ORD || r_state == S_OLD) ? r_j[AW-1:0] : r_t[AW-1:0];

    assign ra_we = (r_state == S_INIT) || (r_cv && r_sq);
    assign ra_wa = r_cv ? r_cj[AW-1:0] : r_j[AW-1:0];
    assign ra_wd = r_cv ? s_rd
                 : ((r_j == '0 || r_j == r_n - 1'b1) ? VALUE_W'(1) : '0);
    assign ra_ra = r_sq ? r_t[AW-1:0] : w_yidx[AW-1:0];
    assign rb_ra = w_yidx[AW-1:0];

    assign s_we  = (r_state == S_WRS);

    cpsp_ram #(.WIDTH(VALUE_W), .DEPTH(N_MAX)) u_vec (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd)
    );

    cpsp_ram #(.WIDTH(VALUE_W), .DEPTH(N_MAX)) u_row_a (
        .i_clk(i_clk), .i_we(ra_we), .i_waddr(ra_wa), .i_wdata(ra_wd),
        .i_raddr(ra_ra), .o_rdata(ra_rd)
    );

    // second copy of the row so squaring reads two entries per cycle
    cpsp_ram #(.WIDTH(VALUE_W), .DEPTH(N_MAX)) u_row_b (
        .i_clk(i_clk), .i_we(ra_we), .i_waddr(ra_wa), .i_wdata(ra_wd),
        .i_raddr(rb_ra), .o_rdata(rb_rd)
    );

    cpsp_ram #(.WIDTH(VALUE_W), .DEPTH(N_MAX)) u_scratch (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(r_d[AW-1:0]), .i_wdata(w_rem),
        .i_raddr(r_j[AW-1:0]), .o_rdata(s_rd)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N_MAX))
        else $error("element count beyond capacity");

    a_mac_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_t < r_n))
        else $error("convolution index out of range");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("product stage without a read");

    a_reduce_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED) |-> (!r_v1 && !r_v2))
        else $error("reduction before accumulation finished");

endmodule
